@@ rtl/sdr_pkg.sv @@
// Package for the supply duty regulator: field widths, payload structs, codes and reset values.
`default_nettype none

package sdr_pkg;

    localparam int DUTY_BITS   = 8;
    localparam int SAMPLE_BITS = 10;
    localparam int TEMP_BITS   = 12;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_VOLTAGE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET_CURRENT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHUTDOWN_TEMP  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FAN_TEMP       = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [SAMPLE_BITS-1:0]      RST_TARGET_VOLTAGE = 10'd94;
    localparam logic [SAMPLE_BITS-1:0]      RST_TARGET_CURRENT = 10'd38;
    localparam logic signed [TEMP_BITS-1:0] RST_SHUTDOWN_TEMP  = 12'sd1120;
    localparam logic signed [TEMP_BITS-1:0] RST_FAN_TEMP       = 12'sd800;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_HALVE     = 3'd1,
        ACT_OVERCURR  = 3'd2,
        ACT_OVERTEMP  = 3'd3,
        ACT_OVERVOLT  = 3'd4,
        ACT_UNDERVOLT = 3'd5
    } action_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]      sample_code;
        logic signed [TEMP_BITS-1:0] temperature;
    } in_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0] duty;
        logic                 alarm;
        logic                 fan_on;
        logic                 next_channel;
        action_t              action;
    } out_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0]      target_voltage_code;
        logic [SAMPLE_BITS-1:0]      target_current_code;
        logic signed [TEMP_BITS-1:0] shutdown_temperature;
        logic signed [TEMP_BITS-1:0] fan_temperature;
    } cfg_t;

    typedef struct packed {
        logic                   measuring_voltage;
        logic [SAMPLE_BITS-1:0] current_code;
        logic [SAMPLE_BITS-1:0] voltage_code;
        logic [DUTY_BITS-1:0]   duty_level;
    } state_t;

endpackage

`default_nettype wire

@@ rtl/supply_duty_regulator.sv @@
// Top level of the supply duty regulator: configuration registers, state and result buffering.
//
// Usage. Each input transfer on in_valid/in_stall carries one converter sample and the
// current heatsink temperature. Samples must alternate current, voltage, current, ...;
// out_data.next_channel tells the converter sequencer which channel to sample next.
// Every accepted input produces exactly one output transfer on out_valid/out_stall,
// carrying the new PWM duty, the alarm and fan flags and the rule that fired.
// An accepted item's result is registered in the output register, or in the skid register
// if that is held. Throughput is one item per cycle while in_stall is low, set by the single
// registered pass through the step logic between the state registers and the output register.
// When the receiver stalls, the output register holds its result and a second skid
// register takes one more result; in_stall is raised only while that skid register is
// full. Configuration writes on cfg_valid/cfg_ready are always taken (cfg_ready is
// tied high) and are meant to happen while the block is idle.
// Reset (rst_n low, asynchronous) restores the default targets and thresholds, clears
// the stored codes and the duty, selects the current channel first and empties both
// output registers.
`default_nettype none

module supply_duty_regulator (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  sdr_pkg::in_t                         in_data,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output sdr_pkg::out_t                        out_data,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [sdr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire  [sdr_pkg::TEMP_BITS-1:0]        cfg_data
);
    import sdr_pkg::*;

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    out_t   step_result;
    out_t   out_reg;
    out_t   skid_reg;
    logic   out_valid_reg;
    logic   skid_valid_reg;
    logic   accept;
    logic   pop;

    // Configuration port: never back-pressures.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_voltage_code  <= RST_TARGET_VOLTAGE;
            cfg_reg.target_current_code  <= RST_TARGET_CURRENT;
            cfg_reg.shutdown_temperature <= RST_SHUTDOWN_TEMP;
            cfg_reg.fan_temperature      <= RST_FAN_TEMP;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TARGET_VOLTAGE: cfg_reg.target_voltage_code  <= cfg_data[SAMPLE_BITS-1:0];
                CFG_TARGET_CURRENT: cfg_reg.target_current_code  <= cfg_data[SAMPLE_BITS-1:0];
                CFG_SHUTDOWN_TEMP:  cfg_reg.shutdown_temperature <= cfg_data;
                CFG_FAN_TEMP:       cfg_reg.fan_temperature      <= cfg_data;
                default:            ;
            endcase
        end
    end

    // The whole regulation rule is one short combinational pass.
    sdr_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (in_data),
        .state_next (state_next),
        .result     (step_result)
    );

    // Input is held off only while the skid register is occupied, which depends on
    // registered state alone.
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign pop      = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output register plus skid register. A full skid register always drains into
    // the output register first, so results leave in the order they were made.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_reg <= step_result;
            end
            else
            begin
                out_reg <= step_result;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The skid register is only ever filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while output register empty");

    // A stalled output with an empty skid register must catch the next accepted item.
    a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("accepted item lost behind a stalled output");

    // Channel selection alternates on every accepted item.
    a_channel_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg.measuring_voltage != $past(state_reg.measuring_voltage)))
        else $error("channel did not alternate");

    // The alarm is raised exactly by the halve and overtemperature rules.
    a_alarm_rule: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.alarm ==
            ((out_reg.action == ACT_HALVE) || (out_reg.action == ACT_OVERTEMP))))
        else $error("alarm disagrees with action");

endmodule

`default_nettype wire

@@ rtl/sdr_step.sv @@
// Combinational regulation step: stores the sample, applies the priority rule, forms the result.
`default_nettype none

module sdr_step (
    input  sdr_pkg::state_t state,
    input  sdr_pkg::cfg_t   cfg,
    input  sdr_pkg::in_t    item,
    output sdr_pkg::state_t state_next,
    output sdr_pkg::out_t   result
);
    import sdr_pkg::*;

    logic [SAMPLE_BITS-1:0] cur;
    logic [SAMPLE_BITS-1:0] vol;
    logic [SAMPLE_BITS+1:0] cur_x2;
    logic [SAMPLE_BITS+1:0] tgt_x3;
    logic [DUTY_BITS-1:0]   duty_dec;
    logic [DUTY_BITS-1:0]   duty_inc;
    logic [DUTY_BITS-1:0]   duty_new;
    action_t                act;
    logic                   alarm;

    assign cur = state.measuring_voltage ? state.current_code : item.sample_code;
    assign vol = state.measuring_voltage ? item.sample_code : state.voltage_code;

    // Three times the limit needs two extra bits; twice the current fits the same width.
    assign cur_x2 = {1'b0, cur, 1'b0};
    assign tgt_x3 = {2'b00, cfg.target_current_code}
                  + {1'b0, cfg.target_current_code, 1'b0};

    assign duty_dec = (state.duty_level == '0) ? '0 : state.duty_level - 1'b1;
    assign duty_inc = (state.duty_level == DUTY_MAX) ? DUTY_MAX : state.duty_level + 1'b1;

    always_comb
    begin
        act      = ACT_NONE;
        alarm    = 1'b0;
        duty_new = state.duty_level;
        if (cur_x2 > tgt_x3)
        begin
            act      = ACT_HALVE;
            alarm    = 1'b1;
            duty_new = state.duty_level >> 1;
        end
        else if (cur > cfg.target_current_code)
        begin
            act      = ACT_OVERCURR;
            duty_new = duty_dec;
        end
        else if (item.temperature > cfg.shutdown_temperature)
        begin
            act      = ACT_OVERTEMP;
            alarm    = 1'b1;
            duty_new = duty_dec;
        end
        else if (vol > cfg.target_voltage_code)
        begin
            act      = ACT_OVERVOLT;
            duty_new = duty_dec;
        end
        else if (vol < cfg.target_voltage_code)
        begin
            act      = ACT_UNDERVOLT;
            duty_new = duty_inc;
        end
    end

    assign state_next.measuring_voltage = ~state.measuring_voltage;
    assign state_next.current_code      = cur;
    assign state_next.voltage_code      = vol;
    assign state_next.duty_level        = duty_new;

    assign result.duty         = duty_new;
    assign result.alarm        = alarm;
    assign result.fan_on       = item.temperature > cfg.fan_temperature;
    assign result.next_channel = ~state.measuring_voltage;
    assign result.action       = act;

endmodule

`default_nettype wire
